@@ hw/rtl/octn_pkg.sv @@
// Shared types and constants for the octahedral normal encoder.
// Holds the item structs, the division stage record and the fixed widths.
// No dependencies.
`default_nettype none

package octn_pkg;

    // Field widths of the input and result items.
    localparam int CMP_BITS  = 16;
    localparam int OUT_BITS  = 16;

    // The sum of three magnitudes stays below 2^(CMP_BITS+1).
    localparam int SUM_BITS  = CMP_BITS + 1;
    // Dividend width: a numerator of SUM_BITS bits times twice the snorm scale.
    localparam int PROD_BITS = SUM_BITS + OUT_BITS;

    // Snorm scale M = 2^(OUT_BITS-1) - 1 and the doubled scale 2M.
    localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic [OUT_BITS-1:0] TWO_MAX = {OUT_MAX[OUT_BITS-2:0], 1'b0};

    typedef struct packed {
        logic signed [CMP_BITS-1:0] vec_x;
        logic signed [CMP_BITS-1:0] vec_y;
        logic signed [CMP_BITS-1:0] vec_z;
    } vec_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] oct_u;
        logic signed [OUT_BITS-1:0] oct_v;
        logic                       zero_vector;
    } oct_item_t;

    // One lane of the long division: partial remainder and a shift word that
    // holds the unused dividend bits on top and the quotient bits below.
    typedef struct packed {
        logic [SUM_BITS-1:0] rem;
        logic [OUT_BITS-1:0] bits;
    } div_lane_t;

    // Record handed from cell to cell.
    typedef struct packed {
        logic [SUM_BITS-1:0] s;
        div_lane_t           lane_u;
        div_lane_t           lane_v;
        logic                neg_x;
        logic                neg_y;
        logic                zero;
    } div_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/octn_front.sv @@
// Front stages of the encoder: magnitudes, octahedral sum and fold, and the
// scaled dividends that feed the division cells. Depends on octn_pkg.
`default_nettype none

module octn_front
    import octn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_stall,
    input  wire vec_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_stall,
    output div_item_t      dn_item
);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] adv;

    logic [CMP_BITS-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [CMP_BITS-1:0] mag_x_next, mag_y_next, mag_z_next;
    logic                neg_x_a_reg, neg_y_a_reg, fold_reg;
    logic                fold_next;

    logic [SUM_BITS-1:0] s_reg, nu_reg, nv_reg;
    logic [SUM_BITS-1:0] s_next, nu_next, nv_next;
    logic                neg_x_b_reg, neg_y_b_reg;

    div_item_t           item_reg;
    div_item_t           item_next;
    logic [PROD_BITS-1:0] prod_u, prod_v;

    // Each stage loads when it is empty or its content moves on.
    always_comb
    begin
        adv[2]      = !vld_reg[2] || !dn_stall;
        adv[1]      = !vld_reg[1] || adv[2];
        adv[0]      = !vld_reg[0] || adv[1];
        vld_next[0] = adv[0] ? up_valid   : vld_reg[0];
        vld_next[1] = adv[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = adv[2] ? vld_reg[1] : vld_reg[2];
    end

    assign up_stall = !adv[0];
    assign dn_valid = vld_reg[2];
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage A: component magnitudes; z at or below zero selects the fold.
    always_comb
    begin
        mag_x_next = up_item.vec_x[CMP_BITS-1] ? (~up_item.vec_x + 1'b1) : up_item.vec_x;
        mag_y_next = up_item.vec_y[CMP_BITS-1] ? (~up_item.vec_y + 1'b1) : up_item.vec_y;
        mag_z_next = up_item.vec_z[CMP_BITS-1] ? (~up_item.vec_z + 1'b1) : up_item.vec_z;
        fold_next  = up_item.vec_z[CMP_BITS-1] || (up_item.vec_z == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag_x_reg   <= mag_x_next;
            mag_y_reg   <= mag_y_next;
            mag_z_reg   <= mag_z_next;
            neg_x_a_reg <= up_item.vec_x[CMP_BITS-1];
            neg_y_a_reg <= up_item.vec_y[CMP_BITS-1];
            fold_reg    <= fold_next;
        end
    end

    // Stage B: the L1 norm and the numerators. In the folded half the
    // numerator s - |y| equals |x| + |z|, and likewise for v.
    always_comb
    begin
        s_next  = SUM_BITS'(mag_x_reg) + SUM_BITS'(mag_y_reg) + SUM_BITS'(mag_z_reg);
        nu_next = fold_reg ? SUM_BITS'(mag_x_reg) + SUM_BITS'(mag_z_reg)
                           : SUM_BITS'(mag_x_reg);
        nv_next = fold_reg ? SUM_BITS'(mag_y_reg) + SUM_BITS'(mag_z_reg)
                           : SUM_BITS'(mag_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s_reg       <= s_next;
            nu_reg      <= nu_next;
            nv_reg      <= nv_next;
            neg_x_b_reg <= neg_x_a_reg;
            neg_y_b_reg <= neg_y_a_reg;
        end
    end

    // Stage C: dividends numerator * 2M, split into the starting remainder
    // and the bits the cells bring down one at a time.
    always_comb
    begin
        prod_u              = PROD_BITS'(nu_reg) * PROD_BITS'(TWO_MAX);
        prod_v              = PROD_BITS'(nv_reg) * PROD_BITS'(TWO_MAX);
        item_next.s         = s_reg;
        item_next.lane_u    = '{rem: prod_u[PROD_BITS-1:OUT_BITS], bits: prod_u[OUT_BITS-1:0]};
        item_next.lane_v    = '{rem: prod_v[PROD_BITS-1:OUT_BITS], bits: prod_v[OUT_BITS-1:0]};
        item_next.neg_x     = neg_x_b_reg;
        item_next.neg_y     = neg_y_b_reg;
        item_next.zero      = (s_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/octn_div_cell.sv @@
// One cell of the division row: a restoring step that yields one quotient
// bit for each lane and hands the record on. Depends on octn_pkg.
`default_nettype none

module octn_div_cell
    import octn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_stall,
    input  wire div_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_stall,
    output div_item_t      dn_item
);

    logic      vld_reg;
    logic      adv;
    div_item_t item_reg;
    div_item_t item_next;

    // Bring down the next dividend bit, subtract the divisor when it fits.
    function automatic div_lane_t div_step(input div_lane_t lane,
                                           input logic [SUM_BITS-1:0] s);
        logic [SUM_BITS:0] trial;
        logic              fits;
        div_lane_t         res;
        trial    = {lane.rem, lane.bits[OUT_BITS-1]};
        fits     = (trial >= {1'b0, s});
        res.rem  = fits ? SUM_BITS'(trial - {1'b0, s}) : trial[SUM_BITS-1:0];
        res.bits = {lane.bits[OUT_BITS-2:0], fits};
        return res;
    endfunction

    assign adv      = !vld_reg || !dn_stall;
    assign up_stall = !adv;
    assign dn_valid = vld_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        item_next        = up_item;
        item_next.lane_u = div_step(up_item.lane_u, up_item.s);
        item_next.lane_v = div_step(up_item.lane_v, up_item.s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/octn_back.sv @@
// Output stage: rounds the doubled quotients half away from zero, applies
// the component signs and holds the result item. Depends on octn_pkg.
`default_nettype none

module octn_back
    import octn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_stall,
    input  wire div_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_stall,
    output oct_item_t      dn_item
);

    logic      vld_reg;
    logic      adv;
    oct_item_t item_reg;
    oct_item_t item_next;

    // The quotient t = floor(2aM/s); the rounded value is (t + 1) / 2.
    function automatic logic [OUT_BITS-1:0] round_sign(input logic [OUT_BITS-1:0] t,
                                                       input logic neg,
                                                       input logic zero);
        logic [OUT_BITS:0]   inc;
        logic [OUT_BITS-1:0] mag;
        inc = {1'b0, t} + 1'b1;
        mag = inc[OUT_BITS:1];
        if (zero)
        begin
            return '0;
        end
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    assign adv      = !vld_reg || !dn_stall;
    assign up_stall = !adv;
    assign dn_valid = vld_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        item_next.oct_u       = round_sign(up_item.lane_u.bits, up_item.neg_x, up_item.zero);
        item_next.oct_v       = round_sign(up_item.lane_v.bits, up_item.neg_y, up_item.zero);
        item_next.zero_vector = up_item.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/octahedral_normal_encoder.sv @@
// Top level of the octahedral normal encoder: front stages, a row of
// division cells and the output stage. Depends on octn_pkg and its submodules.
//
//   Channel   Direction   Handshake            Payload
//   vec       into        vec_valid/vec_stall  vec_item_t (vec_x, vec_y, vec_z)
//   oct       out of      oct_valid/oct_stall  oct_item_t (oct_u, oct_v, zero_vector)
//
// One item enters per cycle while vec_stall is low; each item passes through
// three front stages, one division cell per quotient bit, one output register.
// The row of division cells, one quotient bit each, sets the latency.
// Reset clears only the stage valid bits; no item is in flight after it.
// A stall on the result side fills empty stages first and then reaches vec_stall.
`default_nettype none

module octahedral_normal_encoder
    import octn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      vec_valid,
    output logic           vec_stall,
    input  wire vec_item_t vec_item,
    output logic           oct_valid,
    input  wire logic      oct_stall,
    output oct_item_t      oct_item
);

    localparam int NUM_CELLS = OUT_BITS;

    logic      cell_valid [NUM_CELLS+1];
    logic      cell_stall [NUM_CELLS+1];
    div_item_t cell_item  [NUM_CELLS+1];

    // Magnitudes, norm, fold and scaled dividends.
    octn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vec_valid),
        .up_stall (vec_stall),
        .up_item  (vec_item),
        .dn_valid (cell_valid[0]),
        .dn_stall (cell_stall[0]),
        .dn_item  (cell_item[0])
    );

    // Division row: one quotient bit per cell.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        octn_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[i]),
            .up_stall (cell_stall[i]),
            .up_item  (cell_item[i]),
            .dn_valid (cell_valid[i+1]),
            .dn_stall (cell_stall[i+1]),
            .dn_item  (cell_item[i+1])
        );
    end

    // Rounding, signs and the result register.
    octn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cell_valid[NUM_CELLS]),
        .up_stall (cell_stall[NUM_CELLS]),
        .up_item  (cell_item[NUM_CELLS]),
        .dn_valid (oct_valid),
        .dn_stall (oct_stall),
        .dn_item  (oct_item)
    );

    // A zero vector always comes out as zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        oct_valid && oct_item.zero_vector |-> oct_item.oct_u == '0 && oct_item.oct_v == '0)
        else $error("zero vector item with nonzero coordinates");

    // Rounded coordinates never reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        oct_valid |-> oct_item.oct_u != {1'b1, {(OUT_BITS - 1){1'b0}}}
                   && oct_item.oct_v != {1'b1, {(OUT_BITS - 1){1'b0}}})
        else $error("coordinate outside the snorm range");

    // The input side stalls only when the pipeline is full behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        vec_stall |-> oct_valid && oct_stall)
        else $error("input stalled while the pipeline could advance");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the octahedral normal encoder.
// Streams direction vectors through the valid/stall channels and checks every code
// against an exact integer predictor. Depends on octn_pkg and octahedral_normal_encoder.
`default_nettype none

module testbench;
    import octn_pkg::*;

    localparam int RANDOM_VECTORS   = 1250;
    localparam int QUIET_TAIL       = 150;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int LONG_HOLD_AT     = 400;
    localparam int DRAIN_CYCLES     = OUT_BITS + 12;

    // Magnitude classes used to shape random components.
    typedef enum int {MAG_TINY, MAG_FULL, MAG_EDGE, MAG_ZERO} mag_kind_t;

    // Holds the codes still owed by the encoder and checks each result in order.
    class oct_code_board;
        oct_item_t   expected_codes[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Round half away from zero of mag * M / sum, for mag <= sum.
        function longint snorm_round(longint mag, longint sum);
            longint prod;
            longint quo;
            prod = mag * longint'(OUT_MAX);
            quo  = prod / sum;
            if (2 * (prod % sum) >= sum)
            begin
                quo = quo + 1;
            end
            return quo;
        endfunction

        function logic [OUT_BITS-1:0] apply_sign(longint mag, bit neg);
            longint val;
            val = neg ? -mag : mag;
            return val[OUT_BITS-1:0];
        endfunction

        // Project onto the octahedron and fold the lower half, z <= 0 included.
        function oct_item_t encode_octahedral(vec_item_t v);
            longint    sx, sy, sz;
            longint    ax, ay, az, sum;
            oct_item_t code;
            sx   = longint'($signed(v.vec_x));
            sy   = longint'($signed(v.vec_y));
            sz   = longint'($signed(v.vec_z));
            ax   = (sx < 0) ? -sx : sx;
            ay   = (sy < 0) ? -sy : sy;
            az   = (sz < 0) ? -sz : sz;
            sum  = ax + ay + az;
            code = '0;
            if (sum == 0)
            begin
                code.zero_vector = 1'b1;
            end
            else if (sz <= 0)
            begin
                code.oct_u = apply_sign(snorm_round(sum - ay, sum), sx < 0);
                code.oct_v = apply_sign(snorm_round(sum - ax, sum), sy < 0);
            end
            else
            begin
                code.oct_u = apply_sign(snorm_round(ax, sum), sx < 0);
                code.oct_v = apply_sign(snorm_round(ay, sum), sy < 0);
            end
            return code;
        endfunction

        function void note_vector(vec_item_t v);
            expected_codes = {expected_codes, encode_octahedral(v)};
        endfunction

        function void flag_field(string name, longint want, longint got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        endfunction

        function void check_result(oct_item_t got);
            oct_item_t want;
            if (expected_codes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual u=%0d v=%0d zero=%0b",
                         $time, got.oct_u, got.oct_v, got.zero_vector);
                return;
            end
            want = expected_codes.pop_front();
            if (got.oct_u !== want.oct_u)
            begin
                flag_field("oct_u", want.oct_u, got.oct_u);
            end
            if (got.oct_v !== want.oct_v)
            begin
                flag_field("oct_v", want.oct_v, got.oct_v);
            end
            if (got.zero_vector !== want.zero_vector)
            begin
                flag_field("zero_vector", want.zero_vector, got.zero_vector);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      vec_valid = 1'b0;
    logic      vec_stall;
    vec_item_t vec_item  = '0;
    logic      oct_valid;
    logic      oct_stall = 1'b0;
    oct_item_t oct_item;

    bit quiet_tail    = 1'b0;
    bit long_hold_due = 1'b0;

    oct_code_board board = new();

    octahedral_normal_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_stall (vec_stall),
        .vec_item  (vec_item),
        .oct_valid (oct_valid),
        .oct_stall (oct_stall),
        .oct_item  (oct_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Record accepted vectors and check accepted codes at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vec_valid && !vec_stall)
            begin
                board.note_vector(vec_item);
            end
            if (oct_valid && !oct_stall)
            begin
                board.check_result(oct_item);
            end
        end
    end

    function automatic vec_item_t make_vector(int x, int y, int z);
        vec_item_t v;
        v.vec_x = CMP_BITS'(x);
        v.vec_y = CMP_BITS'(y);
        v.vec_z = CMP_BITS'(z);
        return v;
    endfunction

    function automatic logic [CMP_BITS-1:0] pick_component(mag_kind_t kind);
        int val;
        case (kind)
            MAG_TINY: val = int'($urandom_range(0, 16)) - 8;
            MAG_FULL: val = int'($urandom_range(0, 65535)) - 32768;
            MAG_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0:       val = -32768;
                    1:       val = -32767;
                    2:       val = -1;
                    3:       val = 0;
                    4:       val = 1;
                    default: val = 32767;
                endcase
            end
            default:  val = 0;
        endcase
        return CMP_BITS'(val);
    endfunction

    // Full-range vectors most often, plus tiny, extreme, dominant-axis and flat-z ones.
    function automatic vec_item_t random_vector();
        vec_item_t v;
        mag_kind_t kind [3];
        int        pattern;
        int        lead;
        pattern = $urandom_range(0, 9);
        lead    = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            case (pattern)
                0, 1, 2, 3: kind[i] = MAG_FULL;
                4:          kind[i] = MAG_TINY;
                5:          kind[i] = MAG_EDGE;
                6:          kind[i] = (i == lead) ? MAG_FULL : MAG_TINY;
                8:          kind[i] = (i == 2) ? MAG_ZERO : MAG_FULL;
                default:    kind[i] = mag_kind_t'($urandom_range(0, 3));
            endcase
        end
        v.vec_x = pick_component(kind[0]);
        v.vec_y = pick_component(kind[1]);
        v.vec_z = pick_component(kind[2]);
        return v;
    endfunction

    // Offer one vector, optionally after a short idle burst, and wait until taken.
    task automatic offer_vector(input vec_item_t v, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && !quiet_tail && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            vec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec_item  <= v;
        @(posedge clk);
        while (vec_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: random stall bursts, calm stretches and one long hold-off.
    initial
    begin : result_sink
        bit stall_value;
        int span;
        wait (rst_n);
        forever
        begin
            if (quiet_tail)
            begin
                stall_value = 1'b0;
                span        = 1;
            end
            else if (long_hold_due)
            begin
                stall_value   = 1'b1;
                span          = LONG_HOLD_CYCLES;
                long_hold_due = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_value = 1'b1;
                span        = $urandom_range(1, 4);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_value = 1'b0;
                span        = $urandom_range(20, 60);
            end
            else
            begin
                stall_value = 1'b0;
                span        = $urandom_range(1, 8);
            end
            oct_stall <= stall_value;
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int total;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vector, axis extremes, half-way rounding, z on zero and zero-sign folds.
        offer_vector(make_vector(0, 0, 0), 1'b1);
        offer_vector(make_vector(32767, 0, 0), 1'b1);
        offer_vector(make_vector(-32768, 0, 0), 1'b1);
        offer_vector(make_vector(0, 32767, 0), 1'b1);
        offer_vector(make_vector(0, -32768, 0), 1'b1);
        offer_vector(make_vector(0, 0, 32767), 1'b1);
        offer_vector(make_vector(0, 0, -32768), 1'b1);
        offer_vector(make_vector(32767, 32767, 32767), 1'b1);
        offer_vector(make_vector(-32768, -32768, -32768), 1'b1);
        offer_vector(make_vector(-32768, 32767, -32768), 1'b1);
        offer_vector(make_vector(32767, -32768, 1), 1'b1);
        offer_vector(make_vector(1, 0, 0), 1'b1);
        offer_vector(make_vector(0, -1, 0), 1'b1);
        offer_vector(make_vector(0, 0, 1), 1'b1);
        offer_vector(make_vector(0, 0, -1), 1'b1);
        offer_vector(make_vector(1, 0, 1), 1'b1);
        offer_vector(make_vector(-1, 0, 1), 1'b1);
        offer_vector(make_vector(0, -1, -1), 1'b1);
        offer_vector(make_vector(-1, -1, 1), 1'b1);
        offer_vector(make_vector(1, 1, -1), 1'b1);
        offer_vector(make_vector(3, -5, 0), 1'b1);
        offer_vector(make_vector(0, 7, -9), 1'b1);
        offer_vector(make_vector(-7, 0, -9), 1'b1);
        offer_vector(make_vector(12345, -23456, -3210), 1'b1);
        offer_vector(make_vector(-100, 200, 300), 1'b1);

        // Random part; gaps pause in every third block of 40 and stop near the end.
        total = RANDOM_VECTORS;
        for (int n = 0; n < total; n++)
        begin
            if (n == LONG_HOLD_AT)
            begin
                long_hold_due = 1'b1;
            end
            if (n >= total - QUIET_TAIL)
            begin
                quiet_tail = 1'b1;
            end
            offer_vector(random_vector(), ((n / 40) % 3) != 2);
        end
        vec_valid <= 1'b0;

        while (board.expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard limit, far above the slowest correct run.
    initial
    begin : watchdog
        #200000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
